// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the SHA-1 digest block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/sha1_pkg.sv =====
// Types, constants and control structs of the SHA-1 digest block.
package sha1_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0]       byte_t;
  typedef logic [2:0]       idx_t;
  typedef logic [6:0]       rnd_t;
  typedef logic [5:0]       pos_t;
  typedef logic [63:0]      count_t;
  typedef logic [4:0][31:0] five_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_EMIT
  } state_e;

  localparam five_t H_INIT = '{32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam rnd_t RND_EXPAND = 7'd16;
  localparam rnd_t RND_GRP_1  = 7'd20;
  localparam rnd_t RND_GRP_2  = 7'd40;
  localparam rnd_t RND_GRP_3  = 7'd60;
  localparam rnd_t RND_LAST   = 7'd79;

  localparam byte_t  PAD_BYTE  = 8'h80;
  localparam pos_t   LEN_POS   = 6'd56;
  localparam pos_t   LAST_POS  = 6'd63;
  localparam count_t BYTE_BITS = 64'd8;
  localparam idx_t   IDX_LAST  = 3'd4;

  typedef struct packed {
    logic  shift_byte;
    byte_t byte_val;
    logic  step;
    logic  expand;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    rnd_t round;
  } rnd_ctrl_t;

endpackage

// ===== hdl/sha1_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
interface sha1_in_if;
  logic                valid;
  logic                ready;
  sha1_pkg::byte_t     data_byte;
  logic                byte_present;
  logic                end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic                valid;
  logic                ready;
  sha1_pkg::word_t     digest_word;
  sha1_pkg::idx_t      word_index;
  logic                last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha1_message_digest.sv =====
// SHA-1 digest of a byte stream. A message byte is taken while the block is
// idle; the byte that completes a 64-byte block adds 80 rounds through the
// single shared round unit and a step to fold the result into the chaining
// words, during which the input is not ready. An end item adds the padding at
// one byte per cycle, one or two such compressions and a step to move the
// digest into the output buffer. The five digest words then leave one per
// cycle while the output is ready, and the bytes of the next message are
// already taken meanwhile; if the previous digest has not been delivered when
// the next one is ready, the block holds it back and the input stays not ready
// until the output buffer is empty.
module sha1_message_digest (
  input  logic clk_i,
  input  logic rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);

  sha1_pkg::state_e      state_q, state_d;
  sha1_pkg::count_t      bit_cnt_q, bit_cnt_d;
  sha1_pkg::count_t      len_q, len_d;
  sha1_pkg::rnd_t        rnd_q, rnd_d;
  logic                  end_q, end_d;
  logic                  pad_first_q, pad_first_d;
  logic                  low_seen_q, low_seen_d;
  logic                  final_q, final_d;
  sha1_pkg::five_t       chain_q, chain_d;
  sha1_pkg::five_t       dig_q, dig_d;
  logic                  out_valid_q, out_valid_d;
  sha1_pkg::idx_t        out_idx_q, out_idx_d;

  sha1_pkg::pos_t        pos;
  logic                  accept;
  sha1_pkg::sched_ctrl_t sched_ctrl;
  sha1_pkg::rnd_ctrl_t   rnd_ctrl;
  sha1_pkg::word_t       w;
  sha1_pkg::five_t       vars;

  assign pos        = bit_cnt_q[8:3];
  assign in_i.ready = (state_q == sha1_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha1_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (rnd_ctrl),
    .init_i (chain_q),
    .w_i    (w),
    .vars_o (vars)
  );

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    end_d       = end_q;
    pad_first_d = pad_first_q;
    low_seen_d  = low_seen_q;
    final_d     = final_q;
    chain_d     = chain_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    sched_ctrl  = '0;
    rnd_ctrl    = '0;
    rnd_ctrl.round = rnd_q;

    if (out_valid_q && out_o.ready) begin
      dig_d     = sha1_pkg::five_t'(dig_q >> 32);
      out_idx_d = out_idx_q + 3'd1;
      if (out_idx_q == sha1_pkg::IDX_LAST) begin
        out_valid_d = 1'b0;
      end
    end

    unique case (state_q)
      sha1_pkg::S_IDLE: begin
        if (accept) begin
          if (in_i.byte_present) begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.byte_val   = in_i.data_byte;
            bit_cnt_d             = bit_cnt_q + sha1_pkg::BYTE_BITS;
          end
          if (in_i.end_of_message) begin
            end_d       = 1'b1;
            pad_first_d = 1'b1;
            low_seen_d  = 1'b0;
            len_d       = bit_cnt_d;
            state_d     = sha1_pkg::S_PAD;
          end
          if (in_i.byte_present && pos == sha1_pkg::LAST_POS) begin
            rnd_ctrl.load = 1'b1;
            rnd_d         = '0;
            state_d       = sha1_pkg::S_ROUND;
          end
        end
      end
      sha1_pkg::S_ROUND: begin
        sched_ctrl.step   = 1'b1;
        sched_ctrl.expand = (rnd_q >= sha1_pkg::RND_EXPAND);
        rnd_ctrl.step     = 1'b1;
        rnd_d             = rnd_q + 7'd1;
        if (rnd_q == sha1_pkg::RND_LAST) begin
          state_d = sha1_pkg::S_FOLD;
        end
      end
      sha1_pkg::S_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + vars[i];
        end
        if (final_q) begin
          state_d = sha1_pkg::S_EMIT;
        end else if (end_q) begin
          state_d = sha1_pkg::S_PAD;
        end else begin
          state_d = sha1_pkg::S_IDLE;
        end
      end
      sha1_pkg::S_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        if (pad_first_q) begin
          sched_ctrl.byte_val = sha1_pkg::PAD_BYTE;
        end else if (low_seen_q && pos >= sha1_pkg::LEN_POS) begin
          sched_ctrl.byte_val = len_q[63:56];
          len_d               = {len_q[55:0], 8'h00};
        end else begin
          sched_ctrl.byte_val = '0;
        end
        bit_cnt_d   = bit_cnt_q + sha1_pkg::BYTE_BITS;
        pad_first_d = 1'b0;
        if (pos < sha1_pkg::LEN_POS) begin
          low_seen_d = 1'b1;
        end
        if (pos == sha1_pkg::LAST_POS) begin
          rnd_ctrl.load = 1'b1;
          rnd_d         = '0;
          final_d       = low_seen_q;
          state_d       = sha1_pkg::S_ROUND;
        end
      end
      sha1_pkg::S_EMIT: begin
        if (!out_valid_q) begin
          dig_d       = chain_q;
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          chain_d     = sha1_pkg::H_INIT;
          bit_cnt_d   = '0;
          end_d       = 1'b0;
          final_d     = 1'b0;
          state_d     = sha1_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sha1_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1_pkg::S_IDLE;
      bit_cnt_q   <= '0;
      rnd_q       <= '0;
      end_q       <= 1'b0;
      pad_first_q <= 1'b0;
      low_seen_q  <= 1'b0;
      final_q     <= 1'b0;
      chain_q     <= sha1_pkg::H_INIT;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      rnd_q       <= rnd_d;
      end_q       <= end_d;
      pad_first_q <= pad_first_d;
      low_seen_q  <= low_seen_d;
      final_q     <= final_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    dig_q <= dig_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = dig_q[0];
  assign out_o.word_index  = out_idx_q;
  assign out_o.last_word   = (out_idx_q == sha1_pkg::IDX_LAST);

endmodule

// ===== hdl/sha1_sched.sv =====
// Block buffer and message schedule as one 16-word shift line.
module sha1_sched (
  input  logic                  clk_i,
  input  sha1_pkg::sched_ctrl_t ctrl_i,
  output sha1_pkg::word_t       w_o
);

  sha1_pkg::word_t w_q [16];
  sha1_pkg::word_t mix;
  sha1_pkg::word_t w_next;

  always_comb begin
    mix    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_next = ctrl_i.expand ? {mix[30:0], mix[31]} : w_q[0];
  end

  assign w_o = w_next;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[15] <= {w_q[15][23:0], ctrl_i.byte_val};
    end else if (ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_next;
    end
  end

endmodule

// ===== hdl/sha1_round.sv =====
// Shared SHA-1 round unit holding the five working variables.
module sha1_round (
  input  logic                clk_i,
  input  sha1_pkg::rnd_ctrl_t ctrl_i,
  input  sha1_pkg::five_t     init_i,
  input  sha1_pkg::word_t     w_i,
  output sha1_pkg::five_t     vars_o
);

  sha1_pkg::five_t vars_q;
  sha1_pkg::word_t a, b, c, d, e;
  sha1_pkg::word_t f, k, tmp;

  always_comb begin
    a = vars_q[0];
    b = vars_q[1];
    c = vars_q[2];
    d = vars_q[3];
    e = vars_q[4];
    if (ctrl_i.round < sha1_pkg::RND_GRP_1) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K_0;
    end else if (ctrl_i.round < sha1_pkg::RND_GRP_2) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_1;
    end else if (ctrl_i.round < sha1_pkg::RND_GRP_3) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K_2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + w_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vars_q <= init_i;
    end else if (ctrl_i.step) begin
      vars_q[0] <= tmp;
      vars_q[1] <= a;
      vars_q[2] <= {b[1:0], b[31:2]};
      vars_q[3] <= c;
      vars_q[4] <= d;
    end
  end

  assign vars_o = vars_q;

endmodule

// ===== hdl/sha1_checker.sv =====
// Port-level checks of the SHA-1 digest block and their binding.
`include "assert_macros.svh"

module sha1_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            end_of_message_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input sha1_pkg::word_t digest_word_i,
  input sha1_pkg::idx_t  word_index_i,
  input logic            last_word_i
);

  // A stalled digest word holds its value and position.
  `SHA1_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(digest_word_i) && $stable(word_index_i))

  // The words of one digest follow each other without a gap.
  `SHA1_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_valid_i && out_ready_i && !last_word_i, out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))

  // A digest always starts with its most significant word.
  `SHA1_ASSERT_NOW(a_idx_start, clk_i, rst_ni, $rose(out_valid_i), word_index_i == 3'd0)

  // Taking the last word empties the output buffer.
  `SHA1_ASSERT_NEXT(a_last_empty, clk_i, rst_ni, out_valid_i && out_ready_i && last_word_i, !out_valid_i)

  // An accepted end item leaves idle, so no item is taken next.
  `SHA1_ASSERT_NEXT(a_end_busy, clk_i, rst_ni, in_valid_i && in_ready_i && end_of_message_i, !in_ready_i)

endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .end_of_message_i (in_i.end_of_message),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .digest_word_i    (out_o.digest_word),
  .word_index_i     (out_o.word_index),
  .last_word_i      (out_o.last_word)
);
